// ===== rtl/core/apn_pkg.sv =====
package apn_pkg;

    // Path limits
    localparam int MAX_LEN   = 64;
    localparam int MAX_SEGS  = 32;

    // Storage geometry
    localparam int BUF_DEPTH = 64;
    localparam int BUF_AW    = 6;
    localparam int STK_DEPTH = 32;
    localparam int STK_AW    = 5;

    // Byte codes
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_DOT       = 8'h2E;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUT,
        S_POP,
        S_CLOSE,
        S_DECIDE,
        S_FAIL,
        S_READ
    } apn_state_t;

endpackage

// ===== rtl/core/absolute_path_normalizer_core.sv =====
// Absolute path normalizer.
// Input channel s_*: one path byte per request. s_tdata carries the byte,
// s_tuser flags an empty path (the request ends the path at once, byte
// ignored), s_tlast marks the final byte of the path.
// Output channel m_*: one normalized byte per request, '/'-joined segments.
// m_tuser flags a fail result (m_tdata is 0 then), m_tlast marks the final
// result of the path. An invalid path gives exactly one fail result.
// A byte that continues a segment, or a separator, is taken at once; the
// first byte of a segment also passes the put state (separator and byte
// share the single write port of the output buffer); a ".." close passes
// the pop state for the segment stack read. After the last byte come put
// or pop if that byte opens a segment or closes a "..", then close (then
// pop and close again if it ends a ".." segment), decide, and read or
// fail; an empty-path request goes straight to fail. Results then leave
// at one per cycle, limited by the one read port of the output buffer,
// while the receiver takes them.
// Reset clears all path state; both memories need no clearing pass, since
// every entry is written within a path before it is read.
// When the receiver stalls, the output register holds its request; the block
// keeps taking bytes of a following path and holds the emission of the next
// path until the output register is free.
module absolute_path_normalizer_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] ch
    input  logic       s_tuser,   // [0] empty_path
    input  logic       s_tlast,   // last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tuser,   // [0] fail
    output logic       m_tlast    // out_last
);
    import apn_pkg::*;

    // Memories: normalized bytes and start positions of kept segments
    logic [7:0]        out_buffer [BUF_DEPTH];
    logic [BUF_AW-1:0] seg_stack  [STK_DEPTH];

    apn_state_t state_reg, state_next;

    logic [5:0]        seg_count_reg,  seg_count_next;
    logic [6:0]        write_pos_reg,  write_pos_next;
    logic [5:0]        open_pos_reg,   open_pos_next;
    logic [6:0]        byte_count_reg, byte_count_next;
    logic [1:0]        seg_len_reg,    seg_len_next;   // saturates at 3
    logic              seg_dots_reg,   seg_dots_next;
    logic              in_seg_reg,     in_seg_next;
    logic              failed_reg,     failed_next;
    logic              last_pend_reg,  last_pend_next;
    logic [7:0]        hold_ch_reg,    hold_ch_next;
    logic [5:0]        rd_ptr_reg,     rd_ptr_next;
    logic              out_valid_reg,  out_valid_next;
    logic              out_fail_reg,   out_fail_next;
    logic              out_last_reg,   out_last_next;

    // Memory ports
    logic              ob_we, ob_re;
    logic [BUF_AW-1:0] ob_waddr, ob_raddr;
    logic [7:0]        ob_wdata;
    logic [7:0]        ob_rdata_reg;
    logic              stk_we, stk_re;
    logic [STK_AW-1:0] stk_waddr, stk_raddr;
    logic [BUF_AW-1:0] stk_rdata_reg;

    // Segment close, worked out from the current state
    logic              cl_pop, cl_fail, cl_push;
    logic [6:0]        cl_wpos;
    logic [5:0]        cl_count;

    logic              out_free;
    logic              ch_is_sep;
    logic [6:0]        bc_inc;
    logic              now_failed;

    assign out_free  = !out_valid_reg || m_tready;
    assign ch_is_sep = (s_tdata == CH_SLASH) || (s_tdata == CH_BACKSLASH);
    assign bc_inc    = (byte_count_reg == 7'd127) ? byte_count_reg : byte_count_reg + 7'd1;
    assign now_failed = failed_reg || (bc_inc > 7'(MAX_LEN));

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_fail_reg;
    assign m_tlast  = out_last_reg;
    // A fail result carries a zero byte whatever the read register holds
    assign m_tdata  = out_fail_reg ? 8'd0 : ob_rdata_reg;

    // A lone dot rewinds to the segment start; a dot-dot also pops the stack, or fails
    // when it is empty; anything else is pushed as a kept segment, or fails when it is full.
    always_comb
    begin
        cl_pop   = 1'b0;
        cl_fail  = 1'b0;
        cl_push  = 1'b0;
        cl_wpos  = write_pos_reg;
        cl_count = seg_count_reg;
        if (seg_dots_reg && seg_len_reg == 2'd1)
        begin
            cl_wpos = {1'b0, open_pos_reg};
        end
        else if (seg_dots_reg && seg_len_reg == 2'd2)
        begin
            cl_wpos = {1'b0, open_pos_reg};
            if (seg_count_reg == 6'd0)
            begin
                cl_fail = 1'b1;
            end
            else
            begin
                cl_count = seg_count_reg - 6'd1;
                cl_pop   = 1'b1;
            end
        end
        else if (seg_count_reg >= 6'(MAX_SEGS))
        begin
            cl_fail = 1'b1;
        end
        else
        begin
            cl_push  = 1'b1;
            cl_count = seg_count_reg + 6'd1;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        seg_count_next  = seg_count_reg;
        write_pos_next  = write_pos_reg;
        open_pos_next   = open_pos_reg;
        byte_count_next = byte_count_reg;
        seg_len_next    = seg_len_reg;
        seg_dots_next   = seg_dots_reg;
        in_seg_next     = in_seg_reg;
        failed_next     = failed_reg;
        last_pend_next  = last_pend_reg;
        hold_ch_next    = hold_ch_reg;
        rd_ptr_next     = rd_ptr_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_fail_next   = out_fail_reg;
        out_last_next   = out_last_reg;

        ob_we     = 1'b0;
        ob_waddr  = write_pos_reg[BUF_AW-1:0];
        ob_wdata  = s_tdata;
        ob_re     = 1'b0;
        ob_raddr  = rd_ptr_reg;
        stk_we    = 1'b0;
        stk_waddr = seg_count_reg[STK_AW-1:0];
        stk_re    = 1'b0;
        stk_raddr = cl_count[STK_AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser)
                    begin
                        // Empty path: drop any partial path, emit one fail
                        byte_count_next = 7'd0;
                        failed_next     = 1'b1;
                        last_pend_next  = 1'b0;
                        state_next      = S_FAIL;
                    end
                    else
                    begin
                        byte_count_next = bc_inc;
                        failed_next     = now_failed;
                        last_pend_next  = s_tlast;
                        state_next      = s_tlast ? S_CLOSE : S_IDLE;
                        if (!now_failed)
                        begin
                            if (byte_count_reg == 7'd0)
                            begin
                                if (!ch_is_sep)
                                begin
                                    failed_next = 1'b1;
                                end
                            end
                            else if (ch_is_sep)
                            begin
                                if (in_seg_reg)
                                begin
                                    in_seg_next    = 1'b0;
                                    write_pos_next = cl_wpos;
                                    seg_count_next = cl_count;
                                    stk_we         = cl_push;
                                    stk_re         = cl_pop;
                                    if (cl_fail)
                                    begin
                                        failed_next = 1'b1;
                                    end
                                    if (cl_pop)
                                    begin
                                        state_next = S_POP;
                                    end
                                end
                            end
                            else if (!in_seg_reg)
                            begin
                                // Open a segment: write the separator now, the byte next
                                in_seg_next   = 1'b1;
                                open_pos_next = write_pos_reg[5:0];
                                seg_len_next  = 2'd1;
                                seg_dots_next = (s_tdata == CH_DOT);
                                hold_ch_next  = s_tdata;
                                ob_wdata      = CH_SLASH;
                                if (write_pos_reg < 7'(MAX_LEN))
                                begin
                                    ob_we          = 1'b1;
                                    write_pos_next = write_pos_reg + 7'd1;
                                end
                                else
                                begin
                                    failed_next = 1'b1;
                                end
                                state_next = S_PUT;
                            end
                            else
                            begin
                                if (write_pos_reg < 7'(MAX_LEN))
                                begin
                                    ob_we          = 1'b1;
                                    write_pos_next = write_pos_reg + 7'd1;
                                end
                                else
                                begin
                                    failed_next = 1'b1;
                                end
                                if (seg_len_reg != 2'd3)
                                begin
                                    seg_len_next = seg_len_reg + 2'd1;
                                end
                                if (s_tdata != CH_DOT)
                                begin
                                    seg_dots_next = 1'b0;
                                end
                            end
                        end
                    end
                end
            end

            S_PUT:
            begin
                ob_wdata = hold_ch_reg;
                if (write_pos_reg < 7'(MAX_LEN))
                begin
                    ob_we          = 1'b1;
                    write_pos_next = write_pos_reg + 7'd1;
                end
                else
                begin
                    failed_next = 1'b1;
                end
                state_next = last_pend_reg ? S_CLOSE : S_IDLE;
            end

            S_POP:
            begin
                // Rewind to the start of the popped segment
                write_pos_next = {1'b0, stk_rdata_reg};
                state_next     = last_pend_reg ? S_CLOSE : S_IDLE;
            end

            S_CLOSE:
            begin
                state_next = S_DECIDE;
                if (!failed_reg && in_seg_reg)
                begin
                    in_seg_next    = 1'b0;
                    write_pos_next = cl_wpos;
                    seg_count_next = cl_count;
                    stk_we         = cl_push;
                    stk_re         = cl_pop;
                    if (cl_fail)
                    begin
                        failed_next = 1'b1;
                    end
                    if (cl_pop)
                    begin
                        state_next = S_POP;
                    end
                end
            end

            S_DECIDE:
            begin
                rd_ptr_next = 6'd0;
                if (failed_reg || seg_count_reg == 6'd0 || write_pos_reg == 7'd0)
                begin
                    state_next = S_FAIL;
                end
                else
                begin
                    state_next = S_READ;
                end
            end

            S_FAIL:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_fail_next   = 1'b1;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                    seg_count_next  = 6'd0;
                    write_pos_next  = 7'd0;
                    open_pos_next   = 6'd0;
                    byte_count_next = 7'd0;
                    seg_len_next    = 2'd0;
                    seg_dots_next   = 1'b1;
                    in_seg_next     = 1'b0;
                    failed_next     = 1'b0;
                    last_pend_next  = 1'b0;
                end
            end

            S_READ:
            begin
                if (out_free)
                begin
                    ob_re          = 1'b1;
                    out_valid_next = 1'b1;
                    out_fail_next  = 1'b0;
                    out_last_next  = ({1'b0, rd_ptr_reg} + 7'd1 == write_pos_reg);
                    rd_ptr_next    = rd_ptr_reg + 6'd1;
                    if ({1'b0, rd_ptr_reg} + 7'd1 == write_pos_reg)
                    begin
                        state_next      = S_IDLE;
                        seg_count_next  = 6'd0;
                        write_pos_next  = 7'd0;
                        open_pos_next   = 6'd0;
                        byte_count_next = 7'd0;
                        seg_len_next    = 2'd0;
                        seg_dots_next   = 1'b1;
                        in_seg_next     = 1'b0;
                        failed_next     = 1'b0;
                        last_pend_next  = 1'b0;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            seg_count_reg  <= 6'd0;
            write_pos_reg  <= 7'd0;
            open_pos_reg   <= 6'd0;
            byte_count_reg <= 7'd0;
            seg_len_reg    <= 2'd0;
            seg_dots_reg   <= 1'b1;
            in_seg_reg     <= 1'b0;
            failed_reg     <= 1'b0;
            last_pend_reg  <= 1'b0;
            rd_ptr_reg     <= 6'd0;
            out_valid_reg  <= 1'b0;
            out_fail_reg   <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            seg_count_reg  <= seg_count_next;
            write_pos_reg  <= write_pos_next;
            open_pos_reg   <= open_pos_next;
            byte_count_reg <= byte_count_next;
            seg_len_reg    <= seg_len_next;
            seg_dots_reg   <= seg_dots_next;
            in_seg_reg     <= in_seg_next;
            failed_reg     <= failed_next;
            last_pend_reg  <= last_pend_next;
            rd_ptr_reg     <= rd_ptr_next;
            out_valid_reg  <= out_valid_next;
            out_fail_reg   <= out_fail_next;
            out_last_reg   <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_ch_reg <= hold_ch_next;
    end

    // Output buffer: one write port, registered read that doubles as the
    // output data register (held while the receiver stalls). Reads happen
    // only after the path is complete, so no forwarding is needed.
    always_ff @(posedge clk)
    begin
        if (ob_we)
        begin
            out_buffer[ob_waddr] <= ob_wdata;
        end
        if (ob_re)
        begin
            ob_rdata_reg <= out_buffer[ob_raddr];
        end
    end

    // Segment stack: a pop never reads an entry before its own push has
    // written it, since at least one segment byte lies between them.
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            seg_stack[stk_waddr] <= open_pos_reg;
        end
        if (stk_re)
        begin
            stk_rdata_reg <= seg_stack[stk_raddr];
        end
    end

endmodule

// ===== rtl/core/apn_checker.sv =====
module apn_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tuser,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser,
    input logic       m_tlast
);

    // A fail result is a single zero byte that closes the path
    a_fail_form: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == 8'd0 && m_tlast))
        else $error("fail result not a lone zero final byte");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast)))
        else $error("stalled result changed");

    // An empty-path request ends the path: no request taken next cycle
    a_empty_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser) |=> !s_tready)
        else $error("request taken right after empty path");

    // The final byte of a path starts emission: no request taken next cycle
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !s_tuser && s_tlast) |=> !s_tready)
        else $error("request taken right after final byte");

endmodule

bind absolute_path_normalizer_core apn_checker u_apn_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
